// ----- rtl/vpa_pkg.sv -----
`default_nettype none
package vpa_pkg;
    localparam int FREE_ENTRIES  = 16;
    localparam int OWNED_ENTRIES = 16;
    localparam int MIN_REMAINDER = 10;
    localparam logic [15:0] RESET_MEMORY_SIZE = 16'd1024;
    localparam int FIDX_W = $clog2(FREE_ENTRIES);
    localparam int OIDX_W = (OWNED_ENTRIES > 1) ? $clog2(OWNED_ENTRIES) : 1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [0:0] REG_MEMORY_SIZE = 1'd0;
    localparam logic [0:0] REG_FIT_POLICY  = 1'd1;

    localparam logic [0:0] CMD_FREE = 1'b1;

    // one free extent
    typedef struct packed {
        logic        valid;
        logic [15:0] start;
        logic [15:0] length;
    } t_extent;

    // controls shared by every free cell
    typedef struct packed {
        logic         init;      // load one extent of init_size at entry 0
        logic [15:0]  init_size;
        logic         shift_dn;  // entry i takes entry i+1 from pos up
        logic         shift_up;  // entry i takes entry i-1 above pos
        logic [FIDX_W-1:0] pos;
        logic         wr;        // write entry wr_pos
        logic [FIDX_W-1:0] wr_pos;
        t_extent      wr_data;
    } t_cell_ctl;
endpackage
`default_nettype wire

// ----- rtl/vpa_free_cell.sv -----
`default_nettype none
module vpa_free_cell
    import vpa_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire [FIDX_W-1:0] i_index,
    input  t_cell_ctl        i_ctl,
    input  t_extent          i_above,   // neighbor at index+1
    input  t_extent          i_below,   // neighbor at index-1
    output t_extent          o_entry
);
    t_extent r_entry, n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.init) begin
            n_entry.valid  = (i_index == '0) && (i_ctl.init_size != '0);
            n_entry.start  = '0;
            n_entry.length = (i_index == '0) ? i_ctl.init_size : '0;
        end else if (i_ctl.wr && i_ctl.wr_pos == i_index) begin
            n_entry = i_ctl.wr_data;
        end else if (i_ctl.shift_dn && i_index >= i_ctl.pos) begin
            n_entry = i_above;
        end else if (i_ctl.shift_up && i_index > i_ctl.pos) begin
            n_entry.start  = i_below.start;
            n_entry.length = i_below.length;
            n_entry.valid  = r_entry.valid | i_below.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid  <= (i_index == '0);
            r_entry.start  <= '0;
            r_entry.length <= (i_index == '0) ? RESET_MEMORY_SIZE : '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
endmodule
`default_nettype wire

// ----- rtl/vpa_free_chain.sv -----
`default_nettype none
module vpa_free_chain
    import vpa_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_cell_ctl i_ctl,
    output t_extent   o_entries [FREE_ENTRIES]
);
    t_extent w_ent [FREE_ENTRIES];

    for (genvar g = 0; g < FREE_ENTRIES; g++) begin : g_cell
        t_extent w_above, w_below;
        if (g == FREE_ENTRIES - 1) begin : g_top
            assign w_above = '0;
        end else begin : g_mid
            assign w_above = w_ent[g+1];
        end
        if (g == 0) begin : g_bot
            assign w_below = '0;
        end else begin : g_nb
            assign w_below = w_ent[g-1];
        end
        vpa_free_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (FIDX_W'(g)),
            .i_ctl   (i_ctl),
            .i_above (w_above),
            .i_below (w_below),
            .o_entry (w_ent[g])
        );
    end
    assign o_entries = w_ent;
endmodule
`default_nettype wire

// ----- rtl/variable_partition_allocator_core.sv -----
// Flow: an accepted item walks the owned table (S_OSCAN), then the free cells
//   (S_FSCAN); the apply state (S_APPLY) updates the chain and loads the result
//   register, which is held in S_OUT until the result is accepted.
// Items: one item at a time; the next item is taken only after the result is
//   accepted and the state has returned to idle.
// Reset: synchronous active low; free table holds one extent of 1024, owned
//   table empty, next number zero.
`default_nettype none
module variable_partition_allocator_core
    import vpa_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // req_size, process_id
    input  wire  [0:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // owner_id, start_address, extent_size
    output logic [1:0]  m_axis_tuser    // status
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OSCAN = 3'd1;  // walk owned table
    localparam logic [2:0] S_FSCAN = 3'd2;  // walk free cells
    localparam logic [2:0] S_APPLY = 3'd3;  // update chain, emit result
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]  r_state;
    logic [1:0]  r_policy;
    logic [15:0] r_next_id;
    logic        r_cmd;
    logic [15:0] r_req, r_pid;
    logic [OIDX_W:0] r_oi;
    logic [FIDX_W:0] r_fi;
    logic        r_slot_ok;
    logic [OIDX_W-1:0] r_slot;
    logic        r_pick_ok;
    logic [FIDX_W-1:0] r_pick;
    logic [FIDX_W:0] r_n;     // free count
    logic [FIDX_W:0] r_p;     // insertion point for free
    logic [15:0] r_s, r_l;
    logic [OWNED_ENTRIES-1:0] r_ovalid;
    logic [15:0] r_oid [OWNED_ENTRIES];
    logic [15:0] r_ost [OWNED_ENTRIES];
    logic [15:0] r_olen [OWNED_ENTRIES];

    logic        r_ovld;
    logic [1:0]  r_ostat;
    logic [15:0] r_oown, r_oaddr, r_osize;

    t_cell_ctl w_ctl;
    t_extent   w_ent [FREE_ENTRIES];

    vpa_free_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .o_entries (w_ent)
    );

    wire w_cfg_size = i_cfg_we && i_cfg_index == REG_MEMORY_SIZE;
    assign s_axis_tready = (r_state == S_IDLE) && !w_cfg_size;
    wire w_take = s_axis_tvalid && s_axis_tready;

    t_extent w_cur;
    assign w_cur = w_ent[r_fi[FIDX_W-1:0]];
    wire w_fi_end = (r_fi == (FIDX_W+1)'(FREE_ENTRIES)) || !w_cur.valid;
    wire w_oi_end = r_oi == (OIDX_W+1)'(OWNED_ENTRIES);

    // apply-stage arithmetic
    t_extent w_pk, w_prv, w_nxt;
    logic [16:0] w_rem;
    logic w_mprev, w_mnext;
    logic [FIDX_W-1:0] w_p_lo, w_pm1;
    assign w_pk   = w_ent[r_pick];
    assign w_rem  = {1'b0, w_pk.length} - {1'b0, r_req};
    assign w_p_lo = r_p[FIDX_W-1:0];
    assign w_pm1  = w_p_lo - 1'b1;
    assign w_prv  = w_ent[w_pm1];
    assign w_nxt  = w_ent[w_p_lo];
    assign w_mprev = (r_p != '0) &&
                     ({1'b0, w_prv.start} + {1'b0, w_prv.length} == {1'b0, r_s});
    assign w_mnext = (r_p < r_n) && ({1'b0, r_s} + {1'b0, r_l} == {1'b0, w_nxt.start});

    always_comb begin
        w_ctl = '0;
        w_ctl.init      = w_cfg_size;
        w_ctl.init_size = i_cfg_data;
        if (r_state == S_APPLY && !w_cfg_size) begin
            if (r_cmd != CMD_FREE) begin
                if (r_req != '0 && r_slot_ok && r_pick_ok) begin
                    if (w_rem >= 17'(MIN_REMAINDER)) begin
                        w_ctl.wr      = 1'b1;
                        w_ctl.wr_pos  = r_pick;
                        w_ctl.wr_data = '{valid: 1'b1, start: w_pk.start + r_req,
                                          length: w_rem[15:0]};
                    end else begin
                        w_ctl.shift_dn = 1'b1;
                        w_ctl.pos      = r_pick;
                    end
                end
            end else if (r_slot_ok) begin
                if (w_mprev && w_mnext) begin
                    w_ctl.wr      = 1'b1;
                    w_ctl.wr_pos  = w_pm1;
                    w_ctl.wr_data = '{valid: 1'b1, start: w_prv.start,
                                      length: w_prv.length + r_l + w_nxt.length};
                    w_ctl.shift_dn = 1'b1;
                    w_ctl.pos      = w_p_lo;
                end else if (w_mprev) begin
                    w_ctl.wr      = 1'b1;
                    w_ctl.wr_pos  = w_pm1;
                    w_ctl.wr_data = '{valid: 1'b1, start: w_prv.start,
                                      length: w_prv.length + r_l};
                end else if (w_mnext) begin
                    w_ctl.wr      = 1'b1;
                    w_ctl.wr_pos  = w_p_lo;
                    w_ctl.wr_data = '{valid: 1'b1, start: r_s, length: w_nxt.length + r_l};
                end else if (r_n != (FIDX_W+1)'(FREE_ENTRIES)) begin
                    w_ctl.shift_up = 1'b1;
                    w_ctl.pos      = w_p_lo;
                    w_ctl.wr       = 1'b1;
                    w_ctl.wr_pos   = w_p_lo;
                    w_ctl.wr_data  = '{valid: 1'b1, start: r_s, length: r_l};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_policy  <= '0;
            r_next_id <= '0;
            r_ovalid  <= '0;
            r_ovld    <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovld <= 1'b0;
            if (i_cfg_we && i_cfg_index == REG_FIT_POLICY) r_policy <= i_cfg_data[1:0];
            if (w_cfg_size) r_ovalid <= '0;
            unique case (r_state)
                S_IDLE: if (w_take) begin
                    r_cmd     <= s_axis_tuser[0];
                    r_req     <= s_axis_tdata[15:0];
                    r_pid     <= s_axis_tdata[31:16];
                    r_oi      <= '0;
                    r_fi      <= '0;
                    r_slot_ok <= 1'b0;
                    r_pick_ok <= 1'b0;
                    r_p       <= '0;
                    if (s_axis_tuser[0] != CMD_FREE) r_next_id <= r_next_id + 16'd1;
                    r_state   <= S_OSCAN;
                end
                S_OSCAN: begin
                    // hold first hit: free slot on allocate, matching id on free
                    if (w_oi_end || r_slot_ok) begin
                        r_state <= S_FSCAN;
                    end else begin
                        if (r_cmd != CMD_FREE ? !r_ovalid[r_oi[OIDX_W-1:0]]
                            : (r_ovalid[r_oi[OIDX_W-1:0]] &&
                               r_oid[r_oi[OIDX_W-1:0]] == r_pid)) begin
                            r_slot_ok <= 1'b1;
                            r_slot    <= r_oi[OIDX_W-1:0];
                            r_s       <= r_ost[r_oi[OIDX_W-1:0]];
                            r_l       <= r_olen[r_oi[OIDX_W-1:0]];
                        end
                        r_oi <= r_oi + 1'b1;
                    end
                end
                S_FSCAN: begin
                    if (w_fi_end) begin
                        r_n     <= r_fi;
                        r_state <= S_APPLY;
                    end else begin
                        if (r_cmd != CMD_FREE) begin
                            if (w_cur.length >= r_req) begin
                                if (!r_pick_ok ||
                                    (r_policy == POL_BEST &&
                                     w_cur.length < w_ent[r_pick].length) ||
                                    (r_policy == POL_WORST &&
                                     w_cur.length > w_ent[r_pick].length)) begin
                                    if (!r_pick_ok || r_policy == POL_BEST ||
                                        r_policy == POL_WORST) begin
                                        r_pick_ok <= 1'b1;
                                        r_pick    <= r_fi[FIDX_W-1:0];
                                    end
                                end
                            end
                        end else if (w_cur.start <= r_s) begin
                            r_p <= r_fi + 1'b1;
                        end
                        r_fi <= r_fi + 1'b1;
                    end
                end
                S_APPLY: begin
                    r_ovld  <= 1'b1;
                    r_oaddr <= '0;
                    r_osize <= '0;
                    r_state <= S_OUT;
                    if (r_cmd != CMD_FREE) begin
                        r_oown <= r_next_id;
                        if (r_req == '0) r_ostat <= ST_NO_FIT;
                        else if (!r_slot_ok) r_ostat <= ST_FULL;
                        else if (!r_pick_ok) r_ostat <= ST_NO_FIT;
                        else begin
                            r_ostat <= ST_OK;
                            r_oaddr <= w_pk.start;
                            r_osize <= (w_rem >= 17'(MIN_REMAINDER)) ? r_req : w_pk.length;
                            r_ovalid[r_slot] <= 1'b1;
                            r_oid[r_slot]    <= r_next_id;
                            r_ost[r_slot]    <= w_pk.start;
                            r_olen[r_slot]   <= (w_rem >= 17'(MIN_REMAINDER)) ?
                                                r_req : w_pk.length;
                        end
                    end else begin
                        r_oown <= r_pid;
                        if (!r_slot_ok) r_ostat <= ST_NOT_FOUND;
                        else if (!w_mprev && !w_mnext &&
                                 r_n == (FIDX_W+1)'(FREE_ENTRIES)) r_ostat <= ST_FULL;
                        else begin
                            r_ostat <= ST_OK;
                            r_oaddr <= r_s;
                            r_osize <= r_l;
                            r_ovalid[r_slot] <= 1'b0;
                        end
                    end
                end
                S_OUT: if (!r_ovld || (m_axis_tvalid && m_axis_tready)) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {r_osize, r_oaddr, r_oown};
    assign m_axis_tuser  = r_ostat;
endmodule
`default_nettype wire

// ----- rtl/vpa_checker.sv -----
`default_nettype none
module vpa_checker
    import vpa_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken during work");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[47:16] == 32'd0)
        else $error("failed result carries extent");
endmodule
bind variable_partition_allocator_core vpa_checker u_vpa_checker (.*);
`default_nettype wire

// ----- tb/tb_variable_partition_allocator_core.sv -----
`default_nettype none
module tb_variable_partition_allocator_core;
    import vpa_pkg::*;

    localparam logic [0:0] CMD_ALLOC = 1'b0;
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_UNUSED = 2'd3;

    typedef struct packed {
        logic [0:0]  cmd;
        logic [15:0] req_size;
        logic [15:0] pid;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] owner;
        logic [15:0] start;
        logic [15:0] size;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // req_size, process_id
    logic [0:0]  s_axis_tuser = '0;   // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // owner_id, start_address, extent_size
    logic [1:0]  m_axis_tuser;        // status

    variable_partition_allocator_core dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow copy of the allocator tables
    logic [15:0] region_size;
    logic [1:0]  policy;
    logic [15:0] fr_start [FREE_ENTRIES];
    logic [15:0] fr_len   [FREE_ENTRIES];
    int          fr_count;
    logic [15:0] own_id    [OWNED_ENTRIES];
    logic [15:0] own_start [OWNED_ENTRIES];
    logic [15:0] own_len   [OWNED_ENTRIES];
    logic        own_valid [OWNED_ENTRIES];
    logic [15:0] last_id;

    t_request pending_q[$];
    t_grant   grant_q[$];
    int       mismatches = 0;
    int       grants_seen = 0;
    int       n_ok = 0, n_nofit = 0, n_notfound = 0, n_full = 0;
    bit       hold_sender = 1'b0;

    function automatic void clear_tables();
        fr_count = (region_size != 0) ? 1 : 0;
        fr_start[0] = '0;
        fr_len[0] = region_size;
        foreach (own_valid[i]) own_valid[i] = 1'b0;
    endfunction

    function automatic void drop_extent(int pos);
        for (int i = pos; i + 1 < fr_count; i++) begin
            fr_start[i] = fr_start[i+1];
            fr_len[i] = fr_len[i+1];
        end
        fr_count--;
    endfunction

    function automatic t_grant allocate_extent(logic [15:0] req);
        t_grant g;
        int slot, pick;
        g = '0;
        slot = -1;
        pick = -1;
        last_id = last_id + 16'd1;
        g.owner = last_id;
        if (req == 0) begin
            g.status = ST_NO_FIT;
            return g;
        end
        for (int i = 0; i < OWNED_ENTRIES; i++)
            if (!own_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
            g.status = ST_FULL;
            return g;
        end
        for (int i = 0; i < fr_count; i++) begin
            if (fr_len[i] < req) continue;
            if (pick < 0) begin
                pick = i;
                if (policy != POL_BEST && policy != POL_WORST) break;
            end else if (policy == POL_BEST && fr_len[i] < fr_len[pick]) begin
                pick = i;
            end else if (policy == POL_WORST && fr_len[i] > fr_len[pick]) begin
                pick = i;
            end
        end
        if (pick < 0) begin
            g.status = ST_NO_FIT;
            return g;
        end
        g.start = fr_start[pick];
        if (32'(fr_len[pick]) - 32'(req) >= MIN_REMAINDER) begin
            g.size = req;
            fr_start[pick] += req;
            fr_len[pick] -= req;
        end else begin
            g.size = fr_len[pick];
            drop_extent(pick);
        end
        own_id[slot] = last_id;
        own_start[slot] = g.start;
        own_len[slot] = g.size;
        own_valid[slot] = 1'b1;
        g.status = ST_OK;
        return g;
    endfunction

    function automatic t_grant release_extent(logic [15:0] pid);
        t_grant g;
        int idx, p;
        logic [15:0] s, l;
        bit mprev, mnext;
        g = '0;
        idx = -1;
        p = 0;
        g.owner = pid;
        for (int i = 0; i < OWNED_ENTRIES; i++)
            if (idx < 0 && own_valid[i] && own_id[i] == pid) idx = i;
        if (idx < 0) begin
            g.status = ST_NOT_FOUND;
            return g;
        end
        s = own_start[idx];
        l = own_len[idx];
        while (p < fr_count && fr_start[p] <= s) p++;
        mprev = p > 0 && 32'(fr_start[p-1]) + 32'(fr_len[p-1]) == 32'(s);
        mnext = p < fr_count && 32'(s) + 32'(l) == 32'(fr_start[p]);
        if (mprev && mnext) begin
            fr_len[p-1] = fr_len[p-1] + l + fr_len[p];
            drop_extent(p);
        end else if (mprev) begin
            fr_len[p-1] += l;
        end else if (mnext) begin
            fr_start[p] = s;
            fr_len[p] += l;
        end else begin
            if (fr_count >= FREE_ENTRIES) begin
                g.status = ST_FULL;
                return g;
            end
            for (int i = fr_count; i > p; i--) begin
                fr_start[i] = fr_start[i-1];
                fr_len[i] = fr_len[i-1];
            end
            fr_start[p] = s;
            fr_len[p] = l;
            fr_count++;
        end
        own_valid[idx] = 1'b0;
        g.status = ST_OK;
        g.start = s;
        g.size = l;
        return g;
    endfunction

    // pick a gap length: mostly zero or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // driver: present queued items, idle at random between them
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                t_request r;
                t_grant g;
                r = pending_q.pop_front();
                g = (r.cmd == CMD_FREE) ? release_extent(r.pid)
                                        : allocate_extent(r.req_size);
                grant_q.push_back(g);
            end
            // hold a presented item until it is taken
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_q.size() > 0 &&
                             (!hold_sender || grant_q.size() == 0)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {pending_q[0].pid, pending_q[0].req_size};
                    s_axis_tuser <= pending_q[0].cmd;
                    send_gap <= gap_len();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: stall the result side at random, check every accepted result
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_grant got;
                t_grant want;
                got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                       m_axis_tdata[47:32]};
                grants_seen++;
                if (grant_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d owner %0d start %0d size %0d",
                                 got.status, got.owner, got.start, got.size);
                end else begin
                    want = grant_q.pop_front();
                    case (want.status)
                        ST_OK:        n_ok++;
                        ST_NO_FIT:    n_nofit++;
                        ST_NOT_FOUND: n_notfound++;
                        default:      n_full++;
                    endcase
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp st %0d own %0d st %0d sz %0d,",
                                      " got st %0d own %0d st %0d sz %0d"},
                                     want.status, want.owner, want.start, want.size,
                                     got.status, got.owner, got.start, got.size);
                    end
                end
            end
            if (recv_gap > 0) begin
                m_axis_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_axis_tready <= 1'b1;
                recv_gap <= (m_axis_tvalid && m_axis_tready) ? gap_len() : 0;
            end
        end
    end

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_axis_tvalid || grant_q.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MEMORY_SIZE) begin
            region_size = val;
            clear_tables();
        end else begin
            policy = val[1:0];
        end
    endtask

    function automatic void push_alloc(logic [15:0] sz);
        pending_q.push_back('{CMD_ALLOC, sz, 16'($urandom)});
    endfunction

    function automatic void push_free(logic [15:0] pid);
        pending_q.push_back('{CMD_FREE, 16'($urandom), pid});
    endfunction

    // random phase: half allocations, sizes mostly small; the rest frees, mostly of ids near the last issued one
    task automatic random_phase(int count);
        for (int k = 0; k < count; k++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 50) begin
                int sel;
                sel = $urandom_range(0, 9);
                push_alloc(sel == 0 ? 16'($urandom) :
                           sel == 1 ? 16'd0 : 16'($urandom_range(1, 120)));
            end else if (r < 90) begin
                // free a recent id (last_id lags queue, so aim near issued range)
                push_free(last_id + 16'($urandom_range(0, 20)) - 16'd8);
            end else begin
                push_free(16'($urandom));
            end
            if (pending_q.size() > 8)
                while (pending_q.size() > 2) @(posedge i_clk);
        end
        wait_drained();
    endtask

    initial begin
        region_size = RESET_MEMORY_SIZE;
        policy = POL_FIRST;
        last_id = '0;
        clear_tables();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: zero size, whole-extent grant, miss, merges
        push_alloc(16'd0);
        push_alloc(16'd100);
        push_alloc(16'd200);
        push_alloc(16'd300);
        push_alloc(16'd418);            // remainder below minimum: whole tail
        push_alloc(16'hFFFF);           // no fit
        push_free(16'd3);
        push_free(16'd3);               // not found
        push_free(16'd2);               // merges with next
        push_free(16'd4);
        push_free(16'd5);               // merges with previous
        push_free(16'hFFFF);
        wait_drained();

        // fill the owned table to reach the table-full answer
        for (int i = 0; i < OWNED_ENTRIES + 2; i++) push_alloc(16'd1);
        wait_drained();
        write_reg(REG_MEMORY_SIZE, 16'd1000);
        // fragment the free table
        for (int i = 0; i < 16; i++) push_alloc(16'd10);
        wait_drained();
        for (int i = 0; i < 16; i += 2) push_free(last_id - 16'(i));
        wait_drained();

        write_reg(REG_MEMORY_SIZE, 16'hFFFF);
        write_reg(REG_FIT_POLICY, 16'(POL_BEST));
        // pause the sender after each item until its result is back
        hold_sender = 1'b1;
        push_alloc(16'hFFFF);
        push_free(last_id + 16'd1);
        push_alloc(16'd0);
        push_alloc(16'd500);
        wait_drained();
        hold_sender = 1'b0;

        write_reg(REG_MEMORY_SIZE, 16'd0);
        push_alloc(16'd1);
        wait_drained();

        write_reg(REG_MEMORY_SIZE, 16'd1);
        push_alloc(16'd1);
        push_free(last_id + 16'd1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_FIT_POLICY, 16'(ph == 3 ? POL_UNUSED : ph));
            write_reg(REG_MEMORY_SIZE, ph == 2 ? 16'd65535 : 16'(16'd400 + ph * 300));
            random_phase(160);
        end

        $display("covered %0d results: %0d ok, %0d no fit, %0d not found, %0d full",
                 grants_seen, n_ok, n_nofit, n_notfound, n_full);
        $display("across all four fit policy codes and memory sizes from 0 to 65535");
        if (mismatches == 0 && grant_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
